// ----- src/pid_pkg.sv -----
// pid_pkg: shared constants, microcode field codes and the control store
// for the pid step controller with integral clamp
// no dependencies
package pid_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_STEPS = 53;
	localparam int CNT_W = 6;
	localparam int PC_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ILIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OLIM = 3'd4;

	localparam logic REQ_STEP = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// jump conditions
	localparam logic [2:0] C_NEVER = 3'd0;
	localparam logic [2:0] C_ALWAYS = 3'd1;
	localparam logic [2:0] C_CLEAR = 3'd2;
	localparam logic [2:0] C_DT_ZERO = 3'd3;
	localparam logic [2:0] C_NO_LAST = 3'd4;
	localparam logic [2:0] C_DIV_BUSY = 3'd5;
	localparam logic [2:0] C_KI_ZERO = 3'd6;
	localparam logic [2:0] C_I_IN_RANGE = 3'd7;

	// multiplier operand select
	localparam logic [2:0] MS_NONE = 3'd0;
	localparam logic [2:0] MS_KP_HI = 3'd1;
	localparam logic [2:0] MS_KP_LO = 3'd2;
	localparam logic [2:0] MS_KD_HI = 3'd3;
	localparam logic [2:0] MS_KD_LO = 3'd4;
	localparam logic [2:0] MS_KI_HI = 3'd5;
	localparam logic [2:0] MS_KI_LO = 3'd6;
	localparam logic [2:0] MS_E_DT = 3'd7;

	// datapath operations
	localparam logic [4:0] OP_NOP = 5'd0;
	localparam logic [4:0] OP_LOAD_V_E = 5'd1;
	localparam logic [4:0] OP_ACC_LOAD = 5'd2;
	localparam logic [4:0] OP_WR_P = 5'd3;
	localparam logic [4:0] OP_WR_D = 5'd4;
	localparam logic [4:0] OP_D_ZERO = 5'd5;
	localparam logic [4:0] OP_DIV_RATE = 5'd6;
	localparam logic [4:0] OP_DIV_STEP = 5'd7;
	localparam logic [4:0] OP_LOAD_V_RATE = 5'd8;
	localparam logic [4:0] OP_INTEG_ADD = 5'd9;
	localparam logic [4:0] OP_INTEG_ZERO = 5'd10;
	localparam logic [4:0] OP_WR_I = 5'd11;
	localparam logic [4:0] OP_DIV_BACK = 5'd12;
	localparam logic [4:0] OP_LOAD_INTEG = 5'd13;
	localparam logic [4:0] OP_EMIT_RUN = 5'd14;
	localparam logic [4:0] OP_EMIT_CLEAR = 5'd15;
	localparam logic [4:0] OP_EMIT_REJECT = 5'd16;

	// program labels
	localparam logic [PC_W-1:0] PC_RATE_LOOP = 5'd5;
	localparam logic [PC_W-1:0] PC_D_ZERO = 5'd10;
	localparam logic [PC_W-1:0] PC_INTEG = 5'd11;
	localparam logic [PC_W-1:0] PC_BACK_LOOP = 5'd18;
	localparam logic [PC_W-1:0] PC_EMIT = 5'd20;
	localparam logic [PC_W-1:0] PC_I_ZERO = 5'd21;
	localparam logic [PC_W-1:0] PC_CLEAR = 5'd22;
	localparam logic [PC_W-1:0] PC_REJECT = 5'd23;
	localparam logic [PC_W-1:0] PC_NONE = 5'd0;

	typedef struct packed {
		logic [2:0] cond;
		logic [PC_W-1:0] target;
		logic [2:0] msel;
		logic [4:0] aop;
	} uword_t;

	function automatic uword_t uw(input logic [2:0] cond, input logic [PC_W-1:0] target,
			input logic [2:0] msel, input logic [4:0] aop);
		uword_t w;
		w.cond = cond;
		w.target = target;
		w.msel = msel;
		w.aop = aop;
		return w;
	endfunction

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			5'd0: w = uw(C_CLEAR, PC_CLEAR, MS_NONE, OP_LOAD_V_E);
			5'd1: w = uw(C_DT_ZERO, PC_REJECT, MS_KP_HI, OP_NOP);
			5'd2: w = uw(C_NEVER, PC_NONE, MS_KP_LO, OP_ACC_LOAD);
			5'd3: w = uw(C_NO_LAST, PC_D_ZERO, MS_NONE, OP_WR_P);
			5'd4: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_DIV_RATE);
			5'd5: w = uw(C_DIV_BUSY, PC_RATE_LOOP, MS_NONE, OP_DIV_STEP);
			5'd6: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_LOAD_V_RATE);
			5'd7: w = uw(C_NEVER, PC_NONE, MS_KD_HI, OP_NOP);
			5'd8: w = uw(C_NEVER, PC_NONE, MS_KD_LO, OP_ACC_LOAD);
			5'd9: w = uw(C_ALWAYS, PC_INTEG, MS_NONE, OP_WR_D);
			5'd10: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_D_ZERO);
			5'd11: w = uw(C_KI_ZERO, PC_I_ZERO, MS_E_DT, OP_NOP);
			5'd12: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_INTEG_ADD);
			5'd13: w = uw(C_NEVER, PC_NONE, MS_KI_HI, OP_NOP);
			5'd14: w = uw(C_NEVER, PC_NONE, MS_KI_LO, OP_ACC_LOAD);
			5'd15: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_WR_I);
			5'd16: w = uw(C_I_IN_RANGE, PC_EMIT, MS_NONE, OP_NOP);
			5'd17: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_DIV_BACK);
			5'd18: w = uw(C_DIV_BUSY, PC_BACK_LOOP, MS_NONE, OP_DIV_STEP);
			5'd19: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_LOAD_INTEG);
			5'd20: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_EMIT_RUN);
			5'd21: w = uw(C_ALWAYS, PC_EMIT, MS_NONE, OP_INTEG_ZERO);
			5'd22: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_EMIT_CLEAR);
			5'd23: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_EMIT_REJECT);
			default: w = uw(C_NEVER, PC_NONE, MS_NONE, OP_EMIT_REJECT);
		endcase
		return w;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (!v[65] && (|v[64:31])) begin
			r = 32'sh7FFFFFFF;
		end else if (v[65] && !(&v[64:31])) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
		logic signed [47:0] r;
		if (!v[53] && (|v[52:47])) begin
			r = 48'sh7FFFFFFFFFFF;
		end else if (v[53] && !(&v[52:47])) begin
			r = 48'sh800000000000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

// ----- src/pid_if.sv -----
// pid_req_if, pid_rsp_if: valid/ready channels carrying request and result beats
// no dependencies
interface pid_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic signed [31:0] error_sample;
	logic [20:0] time_step;

	modport source (output valid, req_type, error_sample, time_step, input ready);
	modport sink (input valid, req_type, error_sample, time_step, output ready);
endinterface

interface pid_rsp_if;
	logic valid;
	logic ready;
	logic signed [31:0] drive;
	logic signed [31:0] prop_term;
	logic signed [31:0] integ_term;
	logic signed [31:0] deriv_term;
	logic rejected;

	modport source (output valid, drive, prop_term, integ_term, deriv_term, rejected,
		input ready);
	modport sink (input valid, drive, prop_term, integ_term, deriv_term, rejected,
		output ready);
endinterface

// ----- src/pid_step_antiwindup_top.sv -----
// pid_step_antiwindup_top: microcoded pid step with integral clamp and output clamp
// depends on pid_pkg and the channel interfaces in pid_if.sv
// a clear answers with all terms zero; a zero time step is rejected; otherwise the p term
// is formed, then the d term through the rate divider loop (zero with no previous error),
// then the i term (zero when ki is zero), with a second divider pass when it clamps
// one request in flight; next request is taken as soon as its result is registered
// arst_n clears gains to zero, limits to full scale and the controller state
module pid_step_antiwindup_top (
	input logic clk,
	input logic arst_n,
	pid_req_if.sink req,
	pid_rsp_if.source rsp,
	input logic cfg_we,
	input logic [pid_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pid_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic busy_q;
	logic [pid_pkg::PC_W-1:0] pc_q;
	pid_pkg::uword_t uw;

	logic signed [31:0] kp_q, ki_q, kd_q;
	logic [30:0] ilim_q, olim_q;

	logic signed [31:0] last_err_q;
	logic last_valid_q;
	logic signed [47:0] integ_q;

	logic req_type_q;
	logic signed [31:0] err_q;
	logic [20:0] dt_q;
	logic signed [47:0] v_q;
	logic signed [65:0] prod_q, acc_q;
	logic signed [31:0] p_q, i_q, d_q;
	logic [52:0] num_q;
	logic [31:0] rem_q, dvs_q;
	logic [pid_pkg::CNT_W-1:0] cnt_q;
	logic div_neg_q;

	logic rsp_valid_q;
	logic signed [31:0] drive_q, prop_q, integ_out_q, deriv_q;
	logic rej_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [65:0] term_sum;
	logic signed [31:0] term_sat;
	logic signed [32:0] diff;
	logic [32:0] diff_mag;
	logic [31:0] ki_mag;
	logic signed [53:0] quo_s;
	logic signed [65:0] prod_shr20;
	logic signed [53:0] isum;
	logic signed [33:0] tsum, olim_s;
	logic signed [31:0] drive_c;
	logic signed [32:0] i_ext, ilim_s;
	logic i_ok;
	logic [33:0] trial;
	logic cond_hit, is_emit, hold, act;

	assign uw = pid_pkg::ucode(pc_q);

	assign req.ready = !busy_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.drive = drive_q;
	assign rsp.prop_term = prop_q;
	assign rsp.integ_term = integ_out_q;
	assign rsp.deriv_term = deriv_q;
	assign rsp.rejected = rej_q;

	// shared multiplier operands
	always_comb begin
		unique case (uw.msel)
			pid_pkg::MS_KP_HI: begin mul_a = 33'(kp_q); mul_b = 33'($signed(v_q[47:16])); end
			pid_pkg::MS_KP_LO: begin mul_a = 33'(kp_q); mul_b = {17'b0, v_q[15:0]}; end
			pid_pkg::MS_KD_HI: begin mul_a = 33'(kd_q); mul_b = 33'($signed(v_q[47:16])); end
			pid_pkg::MS_KD_LO: begin mul_a = 33'(kd_q); mul_b = {17'b0, v_q[15:0]}; end
			pid_pkg::MS_KI_HI: begin mul_a = 33'(ki_q); mul_b = 33'($signed(v_q[47:16])); end
			pid_pkg::MS_KI_LO: begin mul_a = 33'(ki_q); mul_b = {17'b0, v_q[15:0]}; end
			pid_pkg::MS_E_DT: begin mul_a = 33'(err_q); mul_b = {12'b0, dt_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign term_sum = acc_q + (prod_q >>> 16);
	assign term_sat = pid_pkg::sat32(term_sum);

	assign diff = 33'(err_q) - 33'(last_err_q);
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign ki_mag = ki_q[31] ? 32'(-ki_q) : 32'(ki_q);
	assign quo_s = div_neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

	assign prod_shr20 = prod_q >>> 20;
	assign isum = 54'(integ_q) + prod_shr20[53:0];

	assign trial = {1'b0, rem_q, num_q[52]} - {2'b0, dvs_q};

	assign i_ext = 33'(i_q);
	assign ilim_s = {2'b0, ilim_q};
	assign i_ok = !(i_ext > ilim_s) && !(i_ext < -ilim_s);

	assign tsum = 34'(p_q) + 34'(i_q) + 34'(d_q);
	assign olim_s = {3'b0, olim_q};
	always_comb begin
		if (tsum > olim_s) begin
			drive_c = olim_s[31:0];
		end else if (tsum < -olim_s) begin
			drive_c = 32'(-olim_s);
		end else begin
			drive_c = tsum[31:0];
		end
	end

	always_comb begin
		unique case (uw.cond)
			pid_pkg::C_NEVER: cond_hit = 1'b0;
			pid_pkg::C_ALWAYS: cond_hit = 1'b1;
			pid_pkg::C_CLEAR: cond_hit = (req_type_q == pid_pkg::REQ_CLEAR);
			pid_pkg::C_DT_ZERO: cond_hit = (dt_q == '0);
			pid_pkg::C_NO_LAST: cond_hit = !last_valid_q;
			pid_pkg::C_DIV_BUSY: cond_hit = (cnt_q != pid_pkg::CNT_W'(1));
			pid_pkg::C_KI_ZERO: cond_hit = (ki_q == '0);
			pid_pkg::C_I_IN_RANGE: cond_hit = i_ok;
			default: cond_hit = 1'b0;
		endcase
	end

	assign is_emit = (uw.aop == pid_pkg::OP_EMIT_RUN) || (uw.aop == pid_pkg::OP_EMIT_CLEAR) ||
		(uw.aop == pid_pkg::OP_EMIT_REJECT);
	assign hold = is_emit && rsp_valid_q && !rsp.ready;
	assign act = busy_q && !hold;

	// sequencer, configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= '0;
			rsp_valid_q <= 1'b0;
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			ilim_q <= '1;
			olim_q <= '1;
			last_err_q <= '0;
			last_valid_q <= 1'b0;
			integ_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pid_pkg::REG_KP: kp_q <= cfg_wdata;
					pid_pkg::REG_KI: ki_q <= cfg_wdata;
					pid_pkg::REG_KD: kd_q <= cfg_wdata;
					pid_pkg::REG_ILIM: ilim_q <= cfg_wdata[30:0];
					pid_pkg::REG_OLIM: olim_q <= cfg_wdata[30:0];
					default: ;
				endcase
			end
			if (act && is_emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (req.valid && !busy_q) begin
				busy_q <= 1'b1;
				pc_q <= '0;
			end
			if (act) begin
				pc_q <= cond_hit ? uw.target : pc_q + 1'b1;
				if (is_emit) begin
					busy_q <= 1'b0;
				end
				unique case (uw.aop)
					pid_pkg::OP_INTEG_ADD: integ_q <= pid_pkg::sat48(isum);
					pid_pkg::OP_INTEG_ZERO: integ_q <= '0;
					pid_pkg::OP_LOAD_INTEG: integ_q <= quo_s[47:0];
					pid_pkg::OP_EMIT_RUN: begin
						last_err_q <= err_q;
						last_valid_q <= 1'b1;
					end
					pid_pkg::OP_EMIT_CLEAR: begin
						last_err_q <= '0;
						last_valid_q <= 1'b0;
						integ_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath and result register
	always_ff @(posedge clk) begin
		if (req.valid && !busy_q) begin
			req_type_q <= req.req_type;
			err_q <= req.error_sample;
			dt_q <= req.time_step;
		end
		if (act) begin
			if (uw.msel != pid_pkg::MS_NONE) begin
				prod_q <= mul_p;
			end
			unique case (uw.aop)
				pid_pkg::OP_LOAD_V_E: v_q <= 48'(err_q);
				pid_pkg::OP_ACC_LOAD: acc_q <= prod_q;
				pid_pkg::OP_WR_P: p_q <= term_sat;
				pid_pkg::OP_WR_D: d_q <= term_sat;
				pid_pkg::OP_D_ZERO: d_q <= '0;
				pid_pkg::OP_WR_I: i_q <= term_sat;
				pid_pkg::OP_INTEG_ZERO: i_q <= '0;
				pid_pkg::OP_DIV_RATE: begin
					num_q <= {diff_mag, 20'b0};
					dvs_q <= {11'b0, dt_q};
					rem_q <= '0;
					div_neg_q <= diff[32];
					cnt_q <= pid_pkg::CNT_W'(pid_pkg::DIV_STEPS);
				end
				pid_pkg::OP_DIV_BACK: begin
					num_q <= {6'b0, ilim_q, 16'b0};
					dvs_q <= ki_mag;
					rem_q <= '0;
					div_neg_q <= ki_q[31] ^ i_q[31];
					cnt_q <= pid_pkg::CNT_W'(pid_pkg::DIV_STEPS);
					i_q <= i_q[31] ? 32'(-ilim_s) : ilim_s[31:0];
				end
				pid_pkg::OP_DIV_STEP: begin
					if (!trial[33]) begin
						rem_q <= trial[31:0];
						num_q <= {num_q[51:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], num_q[52]};
						num_q <= {num_q[51:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
				end
				pid_pkg::OP_LOAD_V_RATE: v_q <= pid_pkg::sat48(quo_s);
				pid_pkg::OP_INTEG_ADD: v_q <= pid_pkg::sat48(isum);
				pid_pkg::OP_EMIT_RUN: begin
					drive_q <= drive_c;
					prop_q <= p_q;
					integ_out_q <= i_q;
					deriv_q <= d_q;
					rej_q <= 1'b0;
				end
				pid_pkg::OP_EMIT_CLEAR: begin
					drive_q <= '0;
					prop_q <= '0;
					integ_out_q <= '0;
					deriv_q <= '0;
					rej_q <= 1'b0;
				end
				pid_pkg::OP_EMIT_REJECT: begin
					drive_q <= '0;
					prop_q <= '0;
					integ_out_q <= '0;
					deriv_q <= '0;
					rej_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- src/pid_chk.sv -----
// pid_chk: port-level checks on the pid step controller, bound to its top level
// depends on pid_step_antiwindup_top and the channel interfaces
module pid_chk (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic signed [31:0] drive,
	input logic signed [31:0] prop_term,
	input logic signed [31:0] integ_term,
	input logic signed [31:0] deriv_term,
	input logic rejected
);

	// a result beat waits until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// a skipped step reports all terms zero
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rejected |-> drive == 0 && prop_term == 0 && integ_term == 0 &&
			deriv_term == 0)
		else $error("rejected beat carries nonzero terms");

	// a result never appears in the cycle right after a request beat
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("result appeared too early");

endmodule

bind pid_step_antiwindup_top pid_chk u_pid_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.drive(rsp.drive),
	.prop_term(rsp.prop_term),
	.integ_term(rsp.integ_term),
	.deriv_term(rsp.deriv_term),
	.rejected(rsp.rejected)
);
